// ===== hw/rtl/assert_macros.svh =====
// Concurrent assertion helpers, clocked and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/urxf_pkg.sv =====
package urxf_pkg;

	localparam int FIFO_DEPTH_DEF = 1024;

	localparam int DATA_W  = 32;
	localparam int IDX_W   = 10;
	localparam int OP_W    = 3;
	localparam int BYTE_W  = 8;

	typedef enum logic [OP_W-1:0] {
		OP_READ  = 3'd0,
		OP_WRITE = 3'd1,
		OP_RX    = 3'd2,
		OP_BREAK = 3'd3,
		OP_TICK  = 3'd4
	} op_t;

	localparam logic [IDX_W-1:0] REG_BAUD  = 10'd0;
	localparam logic [IDX_W-1:0] REG_STAT  = 10'd1;
	localparam logic [IDX_W-1:0] REG_CTRL  = 10'd2;
	localparam logic [IDX_W-1:0] REG_DATA  = 10'd3;
	localparam logic [IDX_W-1:0] REG_MATCH = 10'd4;

	localparam logic [DATA_W-1:0] BAUD_WMASK  = 32'hFF0F_FFFF;
	localparam logic [DATA_W-1:0] STAT_WMASK  = 32'h3E00_0000;
	localparam logic [DATA_W-1:0] STAT_W1C    = 32'h001F_C000;
	localparam logic [DATA_W-1:0] MATCH_WMASK = 32'h03FF_03FF;

	localparam logic [DATA_W-1:0] BAUD_RST = 32'h0F00_0004;
	localparam logic [DATA_W-1:0] STAT_RST = 32'h00C0_0000;
	localparam logic [DATA_W-1:0] DATA_RST = 32'h0000_1000;

	localparam int BAUD_LBKDIE = 15;
	localparam int STAT_LBKDIF = 31;
	localparam int STAT_TDRE   = 23;
	localparam int STAT_RDRF   = 21;
	localparam int STAT_OR     = 19;
	localparam int CTRL_ORIE   = 27;
	localparam int CTRL_TIE    = 23;
	localparam int CTRL_RIE    = 21;
	localparam int CTRL_TE     = 19;
	localparam int CTRL_RE     = 18;

	typedef struct packed {
		logic              push;
		logic              pop;
		logic [BYTE_W-1:0] wr_data;
	} fifo_cmd_t;

	typedef struct packed {
		logic              empty;
		logic              full;
		logic              full_after;
		logic [BYTE_W-1:0] head;
	} fifo_stat_t;

endpackage

// ===== hw/rtl/urxf_ram.sv =====
module urxf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/urxf_fifo.sv =====
module urxf_fifo #(
	parameter int FIFO_DEPTH = urxf_pkg::FIFO_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  urxf_pkg::fifo_cmd_t  cmd,
	output urxf_pkg::fifo_stat_t stat
);

	import urxf_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_n;
	logic [PTR_W-1:0]  wr_ptr_n;
	logic [BYTE_W-1:0] ram_rdata;
	logic [BYTE_W-1:0] fwd_q;
	logic              fwd_hit_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(FIFO_DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	always_comb begin
		rd_ptr_n = cmd.pop  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
		wr_ptr_n = cmd.push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
		stat.empty      = (rd_ptr_q == wr_ptr_q);
		stat.full       = (ptr_inc(wr_ptr_q) == rd_ptr_q);
		stat.full_after = (ptr_inc(wr_ptr_n) == rd_ptr_n);
		stat.head       = fwd_hit_q ? fwd_q : ram_rdata;
	end

	// prefetch the head entry; forward a byte written to the entry being read
	urxf_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(FIFO_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(wr_ptr_q),
		.wdata(cmd.wr_data),
		.raddr(rd_ptr_n),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q  <= '0;
			wr_ptr_q  <= '0;
			fwd_hit_q <= 1'b0;
		end else begin
			rd_ptr_q  <= rd_ptr_n;
			wr_ptr_q  <= wr_ptr_n;
			fwd_hit_q <= cmd.push && (wr_ptr_q == rd_ptr_n);
		end
	end

	always_ff @(posedge clk) begin
		fwd_q <= cmd.wr_data;
	end

endmodule

// ===== hw/rtl/urxf_regs.sv =====
module urxf_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [urxf_pkg::OP_W-1:0]    opcode,
	input  logic [urxf_pkg::IDX_W-1:0]   reg_index,
	input  logic [urxf_pkg::DATA_W-1:0]  write_data,
	input  logic [urxf_pkg::BYTE_W-1:0]  rx_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [urxf_pkg::DATA_W-1:0]  read_data,
	output logic                         irq,
	output logic                         tx_valid,
	output logic [urxf_pkg::BYTE_W-1:0]  tx_byte,
	output logic                         rx_ready,
	output logic                         bad_index,
	output urxf_pkg::fifo_cmd_t          fifo_cmd,
	input  urxf_pkg::fifo_stat_t         fifo_stat
);

	import urxf_pkg::*;

	logic [DATA_W-1:0] baud_q, stat_q, ctrl_q, data_q, match_q;
	logic [DATA_W-1:0] baud_n, stat_n, ctrl_n, data_n, match_n;
	logic              allow_q;
	logic              accept;
	logic [DATA_W-1:0] rd;
	logic              txv;
	logic [BYTE_W-1:0] txb;
	logic              bad;
	logic              irq_n;

	assign in_ready = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		baud_n  = baud_q;
		stat_n  = stat_q;
		ctrl_n  = ctrl_q;
		data_n  = data_q;
		match_n = match_q;
		rd      = '0;
		txv     = 1'b0;
		txb     = '0;
		bad     = 1'b0;
		fifo_cmd.push    = 1'b0;
		fifo_cmd.pop     = 1'b0;
		fifo_cmd.wr_data = rx_byte;
		if (accept) begin
			case (op_t'(opcode))
				OP_READ: begin
					unique case (reg_index)
						REG_BAUD:  rd = baud_q;
						REG_STAT:  rd = stat_q;
						REG_CTRL:  rd = ctrl_q;
						REG_DATA: begin
							stat_n[STAT_RDRF] = 1'b0;
							rd = data_q;
						end
						REG_MATCH: rd = match_q;
						default:   bad = 1'b1;
					endcase
				end
				OP_WRITE: begin
					unique case (reg_index)
						REG_BAUD: baud_n = write_data & BAUD_WMASK;
						REG_STAT: begin
							stat_n = (stat_q & ~STAT_WMASK) | (write_data & STAT_WMASK);
							stat_n = stat_n & ~(write_data & STAT_W1C);
						end
						REG_CTRL: ctrl_n = write_data;
						REG_DATA: begin
							if (ctrl_q[CTRL_TE]) begin
								stat_n[STAT_TDRE] = 1'b1;
								txv = 1'b1;
								txb = write_data[BYTE_W-1:0];
							end
						end
						REG_MATCH: match_n = write_data & MATCH_WMASK;
						default:   bad = 1'b1;
					endcase
				end
				OP_RX: begin
					fifo_cmd.push = ctrl_q[CTRL_RE] && !fifo_stat.full;
				end
				OP_BREAK: begin
					stat_n[STAT_LBKDIF] = 1'b1;
				end
				OP_TICK: begin
					if (!fifo_stat.empty && (!stat_q[STAT_RDRF] || allow_q)) begin
						fifo_cmd.pop = 1'b1;
						if (stat_q[STAT_RDRF]) begin
							stat_n[STAT_OR] = 1'b1;
						end else begin
							data_n[BYTE_W-1:0] = fifo_stat.head;
							stat_n[STAT_RDRF]  = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
		irq_n = (stat_n[STAT_TDRE] && ctrl_n[CTRL_TIE]) ||
			(stat_n[STAT_RDRF] && ctrl_n[CTRL_RIE]) ||
			(stat_n[STAT_OR] && ctrl_n[CTRL_ORIE]) ||
			(stat_n[STAT_LBKDIF] && baud_n[BAUD_LBKDIE]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baud_q    <= BAUD_RST;
			stat_q    <= STAT_RST;
			ctrl_q    <= '0;
			data_q    <= DATA_RST;
			match_q   <= '0;
			allow_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			baud_q  <= baud_n;
			stat_q  <= stat_n;
			ctrl_q  <= ctrl_n;
			data_q  <= data_n;
			match_q <= match_n;
			if (cfg_we) begin
				allow_q <= cfg_wdata;
			end
			if (accept) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// hold the result until its transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			read_data <= rd;
			irq       <= irq_n;
			tx_valid  <= txv;
			tx_byte   <= txb;
			rx_ready  <= ctrl_n[CTRL_RE] && !fifo_stat.full_after;
			bad_index <= bad;
		end
	end

endmodule

// ===== hw/rtl/uart_registers_with_rx_fifo_unit.sv =====
// UART register block with a receive FIFO. Each input transfer carries one bus read, bus write,
// received byte, line break, baud tick or spare opcode and yields one result in the next cycle,
// held in an output register; a new item is taken every cycle while that register is free or
// being emptied, so the block sustains one item per clock. BAUD, STAT, CTRL, DATA and MATCH sit
// in flip-flops; received bytes go to a FIFO_DEPTH-byte RAM with one write and one registered
// read port, which holds up to FIFO_DEPTH - 1 bytes. The head byte is prefetched from the RAM
// every cycle at the next read pointer and forwarded when it is written in the same cycle, so
// a tick moves it to DATA without a wait. The FIFO needs no clearing pass after reset.
module uart_registers_with_rx_fifo_unit #(
	parameter int FIFO_DEPTH = urxf_pkg::FIFO_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [urxf_pkg::OP_W-1:0]    opcode,
	input  logic [urxf_pkg::IDX_W-1:0]   reg_index,
	input  logic [urxf_pkg::DATA_W-1:0]  write_data,
	input  logic [urxf_pkg::BYTE_W-1:0]  rx_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [urxf_pkg::DATA_W-1:0]  read_data,
	output logic                         irq,
	output logic                         tx_valid,
	output logic [urxf_pkg::BYTE_W-1:0]  tx_byte,
	output logic                         rx_ready,
	output logic                         bad_index
);

	import urxf_pkg::*;

	fifo_cmd_t  fifo_cmd;
	fifo_stat_t fifo_stat;

	urxf_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.reg_index (reg_index),
		.write_data(write_data),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.read_data (read_data),
		.irq       (irq),
		.tx_valid  (tx_valid),
		.tx_byte   (tx_byte),
		.rx_ready  (rx_ready),
		.bad_index (bad_index),
		.fifo_cmd  (fifo_cmd),
		.fifo_stat (fifo_stat)
	);

	urxf_fifo #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (fifo_cmd),
		.stat  (fifo_stat)
	);

endmodule

// ===== hw/rtl/urxf_checker.sv =====
`include "assert_macros.svh"

module urxf_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic [urxf_pkg::OP_W-1:0]    opcode,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [urxf_pkg::DATA_W-1:0]  read_data,
	input logic                         tx_valid,
	input logic [urxf_pkg::BYTE_W-1:0]  tx_byte,
	input logic                         bad_index
);

	import urxf_pkg::*;

	logic in_xfer;
	logic is_bus;

	assign in_xfer = in_valid && in_ready;
	assign is_bus  = (opcode == OP_READ) || (opcode == OP_WRITE);

	// serial events, ticks and spare opcodes report no bus result
	`ASSERT_NEXT(a_event_quiet, clk, arst_n, in_xfer && !is_bus,
		out_valid && !bad_index && (read_data == '0) && !tx_valid)
	// a read never transmits
	`ASSERT_NEXT(a_read_no_tx, clk, arst_n, in_xfer && (opcode == OP_READ),
		out_valid && !tx_valid)
	`ASSERT_IMPLY(a_tx_byte_zero, clk, arst_n, out_valid && !tx_valid, tx_byte == '0)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(read_data) && $stable(tx_byte))

endmodule

bind uart_registers_with_rx_fifo_unit urxf_checker u_checker (.*);

// ===== sim/uart_registers_with_rx_fifo_unit_tb.sv =====
`timescale 1ns / 1ps

module uart_registers_with_rx_fifo_unit_tb;
	import urxf_pkg::*;

	localparam int DEPTH = FIFO_DEPTH_DEF;
	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
	localparam logic [IDX_W-1:0] IDX_FIRST_BAD = REG_MATCH + 1'b1;
	localparam logic [IDX_W-1:0] IDX_TOP       = '1;
	localparam int HOLD_AFTER = 700;
	localparam int HOLD_CYCLES = 200;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              irq;
		logic              tx_valid;
		logic [BYTE_W-1:0] tx_byte;
		logic              rx_ready;
		logic              bad_index;
	} uart_result_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] wd;
		logic [BYTE_W-1:0] rb;
		logic              typed;
		uart_result_t      want;
	} stim_row_t;

	typedef enum {MIX_ALL, MIX_FLOOD, MIX_DRAIN} mix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [OP_W-1:0] opcode = '0;
	logic [IDX_W-1:0] reg_index = '0;
	logic [DATA_W-1:0] write_data = '0;
	logic [BYTE_W-1:0] rx_byte = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [DATA_W-1:0] read_data;
	logic irq;
	logic tx_valid;
	logic [BYTE_W-1:0] tx_byte;
	logic rx_ready;
	logic bad_index;

	logic row_typed = 1'b0;
	uart_result_t row_expect = '0;

	logic [DATA_W-1:0] m_baud, m_stat, m_ctrl, m_data, m_match;
	logic [BYTE_W-1:0] m_fifo [0:DEPTH-1];
	int unsigned m_rd_ptr, m_wr_ptr;
	bit m_overrun_ok;

	uart_result_t expected_results [$];
	int errors;
	int items_sent;
	int results_checked;
	int bytes_dropped_full;
	int overruns_seen;
	int bytes_transmitted;
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;

	uart_registers_with_rx_fifo_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.reg_index (reg_index),
		.write_data(write_data),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.read_data (read_data),
		.irq       (irq),
		.tx_valid  (tx_valid),
		.tx_byte   (tx_byte),
		.rx_ready  (rx_ready),
		.bad_index (bad_index)
	);

	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic bit model_fifo_full();
		return ((m_wr_ptr + 1) % DEPTH) == m_rd_ptr;
	endfunction

	task automatic step_uart_model(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
			input logic [DATA_W-1:0] wd, input logic [BYTE_W-1:0] rb,
			output uart_result_t r);
		logic [BYTE_W-1:0] head;
		r = '0;
		case (op)
			OP_READ: begin
				case (idx)
					REG_BAUD:  r.read_data = m_baud;
					REG_STAT:  r.read_data = m_stat;
					REG_CTRL:  r.read_data = m_ctrl;
					REG_DATA: begin
						m_stat[STAT_RDRF] = 1'b0;
						r.read_data = m_data;
					end
					REG_MATCH: r.read_data = m_match;
					default:   r.bad_index = 1'b1;
				endcase
			end
			OP_WRITE: begin
				case (idx)
					REG_BAUD: m_baud = wd & BAUD_WMASK;
					REG_STAT: begin
						m_stat = (m_stat & ~STAT_WMASK) | (wd & STAT_WMASK);
						m_stat = m_stat & ~(wd & STAT_W1C);
					end
					REG_CTRL: m_ctrl = wd;
					REG_DATA: begin
						if (m_ctrl[CTRL_TE]) begin
							m_stat[STAT_TDRE] = 1'b1;
							r.tx_valid = 1'b1;
							r.tx_byte = wd[BYTE_W-1:0];
							bytes_transmitted++;
						end
					end
					REG_MATCH: m_match = wd & MATCH_WMASK;
					default:   r.bad_index = 1'b1;
				endcase
			end
			OP_RX: begin
				if (m_ctrl[CTRL_RE] && !model_fifo_full()) begin
					m_fifo[m_wr_ptr] = rb;
					m_wr_ptr = (m_wr_ptr + 1) % DEPTH;
				end else if (m_ctrl[CTRL_RE]) begin
					bytes_dropped_full++;
				end
			end
			OP_BREAK: m_stat[STAT_LBKDIF] = 1'b1;
			OP_TICK: begin
				if (m_rd_ptr != m_wr_ptr && (!m_stat[STAT_RDRF] || m_overrun_ok)) begin
					head = m_fifo[m_rd_ptr];
					m_rd_ptr = (m_rd_ptr + 1) % DEPTH;
					if (m_stat[STAT_RDRF]) begin
						m_stat[STAT_OR] = 1'b1;
						overruns_seen++;
					end else begin
						m_data[BYTE_W-1:0] = head;
						m_stat[STAT_RDRF] = 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.irq = (m_stat[STAT_TDRE] & m_ctrl[CTRL_TIE]) | (m_stat[STAT_RDRF] & m_ctrl[CTRL_RIE])
			| (m_stat[STAT_OR] & m_ctrl[CTRL_ORIE])
			| (m_stat[STAT_LBKDIF] & m_baud[BAUD_LBKDIE]);
		r.rx_ready = m_ctrl[CTRL_RE] && !model_fifo_full();
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] exp_v,
			input logic [DATA_W-1:0] act_v);
		if (act_v !== exp_v) begin
			errors++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		uart_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				step_uart_model(opcode, reg_index, write_data, rx_byte, want);
				if (row_typed)
					want = row_expect;
				expected_results.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result transfer with nothing expected, read_data 0x%0h",
						$time, read_data);
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					check_field("read_data", want.read_data, read_data);
					check_field("irq", want.irq, irq);
					check_field("tx_valid", want.tx_valid, tx_valid);
					check_field("tx_byte", want.tx_byte, tx_byte);
					check_field("rx_ready", want.rx_ready, rx_ready);
					check_field("bad_index", want.bad_index, bad_index);
				end
			end
		end
	end

	// receiver: random stalls, one long hold-off to back up the input
	initial begin
		int stall;
		int taken;
		bit hold_done;
		taken = 0;
		hold_done = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = rx_idle ? $urandom_range(0, 6) : 0;
			if (!hold_done && taken >= HOLD_AFTER) begin
				stall = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	function automatic stim_row_t row(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
			input logic [DATA_W-1:0] wd, input logic [BYTE_W-1:0] rb,
			input logic typed, input uart_result_t want);
		stim_row_t s;
		s.op = op;
		s.idx = idx;
		s.wd = wd;
		s.rb = rb;
		s.typed = typed;
		s.want = want;
		return s;
	endfunction

	function automatic stim_row_t draw_item(input mix_t mix);
		int r;
		logic [OP_W-1:0] op;
		logic [IDX_W-1:0] idx;
		logic [DATA_W-1:0] wd;
		r = $urandom_range(0, 99);
		idx = ($urandom_range(0, 6) == 0) ? IDX_W'($urandom_range(0, 1023))
			: IDX_W'($urandom_range(0, 4));
		wd = $urandom;
		case (mix)
			MIX_FLOOD: op = (r < 97) ? OP_RX : (r < 99) ? OP_READ : OP_TICK;
			MIX_DRAIN: op = (r < 45) ? OP_TICK : (r < 70) ? OP_READ : (r < 80) ? OP_RX
				: (r < 90) ? OP_WRITE : (r < 95) ? OP_BREAK
				: OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
			default:   op = (r < 20) ? OP_READ : (r < 40) ? OP_WRITE : (r < 65) ? OP_RX
				: (r < 70) ? OP_BREAK : (r < 92) ? OP_TICK
				: OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		endcase
		if (mix == MIX_DRAIN && op == OP_READ && $urandom_range(0, 1) == 0)
			idx = REG_DATA;
		if (op == OP_WRITE && idx == REG_CTRL && $urandom_range(0, 4) != 0)
			wd = wd | (DATA_W'(1) << CTRL_RE) | (DATA_W'(1) << CTRL_TE);
		if (op == OP_WRITE && idx == REG_STAT && $urandom_range(0, 1) == 0)
			wd = wd & ~STAT_W1C;
		return row(op, idx, wd, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
	endfunction

	task automatic offer(input stim_row_t s);
		int gap;
		gap = tx_idle ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= s.op;
		reg_index <= s.idx;
		write_data <= s.wd;
		rx_byte <= s.rb;
		row_typed <= s.typed;
		row_expect <= s.want;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_overrun_mode(input bit allow);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= allow;
		m_overrun_ok = allow;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input mix_t mix, input int count);
		stim_row_t s;
		for (int i = 0; i < count; i++) begin
			if (i % 64 == 0) begin
				tx_idle = $urandom_range(0, 2) != 0;
				rx_idle = $urandom_range(0, 2) != 0;
			end
			s = draw_item(mix);
			// keep the receiver on so the flood can fill the FIFO
			if (mix == MIX_FLOOD && i == 0)
				s = row(OP_WRITE, REG_CTRL, $urandom | (DATA_W'(1) << CTRL_RE), '0, 1'b0, '0);
			offer(s);
		end
	endtask

	initial begin
		stim_row_t directed [$];
		m_baud = BAUD_RST;
		m_stat = STAT_RST;
		m_ctrl = '0;
		m_data = DATA_RST;
		m_match = '0;
		m_rd_ptr = 0;
		m_wr_ptr = 0;
		m_overrun_ok = 1'b0;
		errors = 0;
		items_sent = 0;
		results_checked = 0;
		bytes_dropped_full = 0;
		overruns_seen = 0;
		bytes_transmitted = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_overrun_mode(1'b0);

		directed.push_back(row(OP_READ, REG_BAUD, '0, '0, 1'b1, '{BAUD_RST, 0, 0, 0, 0, 0}));
		directed.push_back(row(OP_READ, REG_STAT, '0, '0, 1'b1, '{STAT_RST, 0, 0, 0, 0, 0}));
		directed.push_back(row(OP_READ, REG_CTRL, '0, '0, 1'b1, '{'0, 0, 0, 0, 0, 0}));
		directed.push_back(row(OP_READ, REG_DATA, '0, '0, 1'b1, '{DATA_RST, 0, 0, 0, 0, 0}));
		directed.push_back(row(OP_READ, REG_MATCH, '0, '0, 1'b1, '{'0, 0, 0, 0, 0, 0}));
		directed.push_back(row(OP_READ, IDX_FIRST_BAD, '0, '0, 1'b1, '{'0, 0, 0, 0, 0, 1}));
		directed.push_back(row(OP_WRITE, IDX_TOP, '1, '1, 1'b1, '{'0, 0, 0, 0, 0, 1}));
		directed.push_back(row(OP_RX, REG_BAUD, '0, 8'h5A, 1'b0, '0));
		directed.push_back(row(OP_TICK, REG_BAUD, '0, '0, 1'b0, '0));
		directed.push_back(row(OP_WRITE, REG_BAUD, '1, '0, 1'b0, '0));
		directed.push_back(row(OP_WRITE, REG_MATCH, '1, '0, 1'b0, '0));
		directed.push_back(row(OP_WRITE, REG_STAT, '1, '0, 1'b0, '0));
		directed.push_back(row(OP_BREAK, REG_BAUD, '0, '0, 1'b0, '0));
		directed.push_back(row(OP_WRITE, REG_CTRL, '1, '0, 1'b0, '0));
		directed.push_back(row(OP_WRITE, REG_DATA, 32'h0000_00FF, '0, 1'b0, '0));
		directed.push_back(row(OP_RX, REG_BAUD, '0, 8'h00, 1'b0, '0));
		directed.push_back(row(OP_RX, REG_BAUD, '0, 8'hFF, 1'b0, '0));
		directed.push_back(row(OP_TICK, REG_BAUD, '0, '0, 1'b0, '0));
		directed.push_back(row(OP_TICK, REG_BAUD, '0, '0, 1'b0, '0));
		directed.push_back(row(OP_READ, REG_DATA, '0, '0, 1'b0, '0));
		directed.push_back(row(OP_TICK, REG_BAUD, '0, '0, 1'b0, '0));
		directed.push_back(row(OP_WRITE, REG_STAT, '0, '0, 1'b0, '0));
		directed.push_back(row(OP_SPARE_FIRST, IDX_TOP, '1, '1, 1'b0, '0));
		directed.push_back(row(OP_SPARE_LAST, IDX_TOP, '1, '1, 1'b0, '0));
		directed.push_back(row(OP_WRITE, REG_CTRL, '0, '0, 1'b0, '0));
		directed.push_back(row(OP_WRITE, REG_DATA, 32'hFFFF_FFA5, '0, 1'b0, '0));
		foreach (directed[i])
			offer(directed[i]);

		set_overrun_mode(1'b1);
		run_phase(MIX_ALL, 200);
		set_overrun_mode(1'b0);
		run_phase(MIX_ALL, 200);
		set_overrun_mode(1'b1);
		run_phase(MIX_FLOOD, 1150);
		set_overrun_mode(1'b0);
		run_phase(MIX_DRAIN, 150);
		wait_drained();
		repeat (8) @(posedge clk);

		$display("%0d items sent, %0d results checked, both overrun settings exercised",
			items_sent, results_checked);
		$display("%0d bytes dropped on a full FIFO, %0d overruns, %0d bytes transmitted",
			bytes_dropped_full, overruns_seen, bytes_transmitted);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== uart_registers_with_rx_fifo_unit.f =====
+incdir+hw/rtl
hw/rtl/urxf_pkg.sv
hw/rtl/urxf_ram.sv
hw/rtl/urxf_fifo.sv
hw/rtl/urxf_regs.sv
hw/rtl/uart_registers_with_rx_fifo_unit.sv
hw/rtl/urxf_checker.sv
sim/uart_registers_with_rx_fifo_unit_tb.sv
